FILE: rtl/htdig_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package htdig_pkg;

  localparam logic [1:0] OP_VERTEX = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_FACE   = 2'd2;

  localparam logic [1:0] REG_POINTS_R = 2'd0;
  localparam logic [1:0] REG_POINTS_S = 2'd1;
  localparam logic [1:0] REG_POINTS_T = 2'd2;

  // Corner selection of the eight vertices, bit k belongs to vertex k.
  localparam logic [7:0] VERT_R = 8'b0110_1100;
  localparam logic [7:0] VERT_S = 8'b1100_0110;
  localparam logic [7:0] VERT_T = 8'b1111_0000;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_MUL1,
    ACT_MUL2,
    ACT_BASE,
    ACT_EMIT
  } act_t;

  typedef enum logic [1:0] {
    CND_NEVER,
    CND_IN_FIRE,
    CND_LAST_FIRE
  } cond_t;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_MUL1 = 3'd1;
  localparam step_t STEP_MUL2 = 3'd2;
  localparam step_t STEP_BASE = 3'd3;
  localparam step_t STEP_EMIT = 3'd4;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
    logic  hold;
  } ucode_t;

  typedef enum logic [2:0] {
    IS_ONE,
    IS_NEG_ONE,
    IS_PR,
    IS_NEG_PR,
    IS_PLANE
  } istep_t;

  typedef enum logic {
    OS_PR,
    OS_PLANE
  } ostep_t;

  typedef enum logic [1:0] {
    CNT_ONE,
    CNT_PR,
    CNT_PS,
    CNT_PT
  } cnt_t;

  typedef struct packed {
    logic   rsel;
    logic   ssel;
    logic   tsel;
    istep_t istep;
    ostep_t ostep;
    cnt_t   icnt;
    cnt_t   ocnt;
    logic   bad;
  } desc_t;

  // Control store: one word per step of the sequencer.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{act: ACT_NONE, cond: CND_NEVER, target: STEP_IDLE, hold: 1'b0};
    unique case (s)
      STEP_IDLE: w = '{act: ACT_LOAD, cond: CND_IN_FIRE, target: STEP_MUL1, hold: 1'b1};
      STEP_MUL1: w = '{act: ACT_MUL1, cond: CND_NEVER, target: STEP_IDLE, hold: 1'b0};
      STEP_MUL2: w = '{act: ACT_MUL2, cond: CND_NEVER, target: STEP_IDLE, hold: 1'b0};
      STEP_BASE: w = '{act: ACT_BASE, cond: CND_NEVER, target: STEP_IDLE, hold: 1'b0};
      STEP_EMIT: w = '{act: ACT_EMIT, cond: CND_LAST_FIRE, target: STEP_IDLE, hold: 1'b1};
      default:   w = '{act: ACT_NONE, cond: CND_NEVER, target: STEP_IDLE, hold: 1'b0};
    endcase
    return w;
  endfunction

  function automatic desc_t decode_entity(input logic [1:0] op, input logic [3:0] ent);
    desc_t d;
    d = '{rsel: 1'b0, ssel: 1'b0, tsel: 1'b0, istep: IS_ONE, ostep: OS_PR,
          icnt: CNT_ONE, ocnt: CNT_ONE, bad: 1'b1};
    unique case (op)
      OP_VERTEX: begin
        if (ent < 4'd8) begin
          d.rsel = VERT_R[ent[2:0]];
          d.ssel = VERT_S[ent[2:0]];
          d.tsel = VERT_T[ent[2:0]];
          d.bad  = 1'b0;
        end
      end
      OP_EDGE: begin
        d.bad = 1'b0;
        unique case (ent)
          4'd0: begin
            d.istep = IS_PR; d.icnt = CNT_PS;
          end
          4'd1: begin
            d.ssel = 1'b1; d.istep = IS_ONE; d.icnt = CNT_PR;
          end
          4'd2: begin
            d.rsel = 1'b1; d.istep = IS_PR; d.icnt = CNT_PS;
          end
          4'd3: begin
            d.istep = IS_ONE; d.icnt = CNT_PR;
          end
          4'd4: begin
            d.tsel = 1'b1; d.istep = IS_ONE; d.icnt = CNT_PR;
          end
          4'd5: begin
            d.tsel = 1'b1; d.rsel = 1'b1; d.istep = IS_PR; d.icnt = CNT_PS;
          end
          4'd6: begin
            d.tsel = 1'b1; d.ssel = 1'b1; d.istep = IS_ONE; d.icnt = CNT_PR;
          end
          4'd7: begin
            d.tsel = 1'b1; d.istep = IS_PR; d.icnt = CNT_PS;
          end
          4'd8: begin
            d.rsel = 1'b1; d.istep = IS_PLANE; d.icnt = CNT_PT;
          end
          4'd9: begin
            d.istep = IS_PLANE; d.icnt = CNT_PT;
          end
          4'd10: begin
            d.ssel = 1'b1; d.istep = IS_PLANE; d.icnt = CNT_PT;
          end
          4'd11: begin
            d.ssel = 1'b1; d.rsel = 1'b1; d.istep = IS_PLANE; d.icnt = CNT_PT;
          end
          default: d.bad = 1'b1;
        endcase
      end
      OP_FACE: begin
        d.bad   = 1'b0;
        d.ocnt  = (ent < 4'd2) ? CNT_PS : CNT_PT;
        d.ostep = (ent < 4'd2) ? OS_PR : OS_PLANE;
        d.icnt  = (ent < 4'd4) ? CNT_PR : CNT_PS;
        unique case (ent)
          4'd0: d.istep = IS_ONE;
          4'd1: begin
            d.tsel = 1'b1; d.istep = IS_ONE;
          end
          4'd2: d.istep = IS_ONE;
          4'd3: begin
            d.ssel = 1'b1; d.rsel = 1'b1; d.istep = IS_NEG_ONE;
          end
          4'd4: begin
            d.rsel = 1'b1; d.istep = IS_PR;
          end
          4'd5: begin
            d.ssel = 1'b1; d.istep = IS_NEG_PR;
          end
          default: begin
            d = '{rsel: 1'b0, ssel: 1'b0, tsel: 1'b0, istep: IS_ONE, ostep: OS_PR,
                  icnt: CNT_ONE, ocnt: CNT_ONE, bad: 1'b1};
          end
        endcase
      end
      default: d.bad = 1'b1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hex_tensor_dof_index_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Hexahedron closure index generator. Each input transaction names an entity
// kind (vertex, edge or face) in in_tuser and an entity number in in_tdata, and
// the block answers with one output transaction per grid point of that entity,
// giving the linear index r + s*points_r + t*points_r*points_s with r fastest.
// out_tlast marks the final index of a request; an unknown entity or kind gives
// a single index 0 with out_tuser set. A request yields n indices (1 for a
// vertex, up to MAX_POINTS for an edge, up to MAX_POINTS squared for a face):
// the idle step accepts it, three setup steps of the sequencer form the plane
// size and start index with three small multipliers, and then the emit step
// gives one index per cycle while out_tready is high. in_tready is high only
// between requests. Point counts are to be written through the APB port while
// the block is idle; the block does not enforce it. Values below 2 or above
// MAX_POINTS are used as 2 or MAX_POINTS but read back as written.

module hex_tensor_dof_index_generator #(
  parameter int MAX_POINTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [3:0] entity
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [8:0] point_index
  output logic             out_tlast,
  output logic             out_tuser,  // [0] bad_entity
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  import htdig_pkg::*;

  localparam int CW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam logic [3:0] MAXP = 4'(MAX_POINTS);

  function automatic logic [3:0] clamp_pts(input logic [3:0] v);
    logic [3:0] c;
    c = v;
    if (v < 4'd2) c = 4'd2;
    else if (v > MAXP) c = MAXP;
    return c;
  endfunction

  logic [3:0] points_r_r, points_s_r, points_t_r;
  logic [3:0] pr, ps, pt;
  logic [3:0] rm, sm, tm;

  step_t    step_r, step_nxt;
  ucode_t   uw;
  desc_t    desc_r;
  logic [6:0] plane_r;
  logic [5:0] smpr_r;
  logic [8:0] top_r;
  logic [8:0] idx_r, row_r;
  logic [CW-1:0] i_r, j_r, icnt_m1_r, ocnt_m1_r;

  logic        out_valid_r, out_last_r, out_bad_r;
  logic [8:0]  out_idx_r;

  logic        in_fire, out_free, emit_fire, row_end, is_last;
  logic [8:0]  istride, ostride, base;
  logic        cond_true;
  logic        cfg_wr;

  function automatic logic [CW-1:0] cnt_m1(input cnt_t c, input logic [3:0] a,
                                           input logic [3:0] b, input logic [3:0] d);
    logic [3:0] v;
    v = 4'd1;
    case (c)
      CNT_PR:  v = a;
      CNT_PS:  v = b;
      CNT_PT:  v = d;
      default: v = 4'd1;
    endcase
    return CW'(v - 4'd1);
  endfunction

  assign pr = clamp_pts(points_r_r);
  assign ps = clamp_pts(points_s_r);
  assign pt = clamp_pts(points_t_r);
  assign rm = pr - 4'd1;
  assign sm = ps - 4'd1;
  assign tm = pt - 4'd1;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_POINTS_R: cfg_prdata = {28'd0, points_r_r};
      REG_POINTS_S: cfg_prdata = {28'd0, points_s_r};
      REG_POINTS_T: cfg_prdata = {28'd0, points_t_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r_r <= 4'd5;
      points_s_r <= 4'd5;
      points_t_r <= 4'd5;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_POINTS_R: points_r_r <= cfg_pwdata[3:0];
        REG_POINTS_S: points_s_r <= cfg_pwdata[3:0];
        REG_POINTS_T: points_t_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  assign uw        = ucode_rom(step_r);
  assign in_tready = (uw.act == ACT_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign emit_fire = (uw.act == ACT_EMIT) && out_free;
  assign row_end   = (i_r == icnt_m1_r);
  assign is_last   = row_end && (j_r == ocnt_m1_r);

  always_comb begin
    case (uw.cond)
      CND_IN_FIRE:   cond_true = in_fire;
      CND_LAST_FIRE: cond_true = emit_fire && is_last;
      default:       cond_true = 1'b0;
    endcase
    if (cond_true) step_nxt = uw.target;
    else if (uw.hold) step_nxt = step_r;
    else step_nxt = step_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= STEP_IDLE;
    else step_r <= step_nxt;
  end

  always_comb begin
    case (desc_r.istep)
      IS_NEG_ONE: istride = 9'h1FF;
      IS_PR:      istride = {5'd0, pr};
      IS_NEG_PR:  istride = 9'd0 - {5'd0, pr};
      IS_PLANE:   istride = {2'd0, plane_r};
      default:    istride = 9'd1;
    endcase
    ostride = (desc_r.ostep == OS_PLANE) ? {2'd0, plane_r} : {5'd0, pr};
    base = (desc_r.rsel ? {5'd0, rm} : 9'd0)
         + (desc_r.ssel ? {3'd0, smpr_r} : 9'd0)
         + (desc_r.tsel ? top_r : 9'd0);
  end

  always_ff @(posedge clk) begin
    case (uw.act)
      ACT_LOAD: if (in_fire) desc_r <= decode_entity(in_tuser, in_tdata[3:0]);
      ACT_MUL1: begin
        plane_r <= 7'({3'd0, pr} * {3'd0, ps});
        smpr_r  <= 6'({2'd0, sm} * {2'd0, pr});
      end
      ACT_MUL2: top_r <= {5'd0, tm} * {2'd0, plane_r};
      ACT_BASE: begin
        idx_r     <= base;
        row_r     <= base;
        i_r       <= '0;
        j_r       <= '0;
        icnt_m1_r <= cnt_m1(desc_r.icnt, pr, ps, pt);
        ocnt_m1_r <= cnt_m1(desc_r.ocnt, pr, ps, pt);
      end
      ACT_EMIT: begin
        if (emit_fire) begin
          if (row_end) begin
            i_r   <= '0;
            j_r   <= j_r + CW'(1);
            row_r <= row_r + ostride;
            idx_r <= row_r + ostride;
          end else begin
            i_r   <= i_r + CW'(1);
            idx_r <= idx_r + istride;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_idx_r  <= desc_r.bad ? 9'd0 : idx_r;
      out_last_r <= is_last;
      out_bad_r  <= desc_r.bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sequencer still ready after taking a request");

  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == 16'd0))
    else $error("flagged result is not a single zero index");

  a_idle_only_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && in_tready |-> out_tlast)
    else $error("ready for a new request while a run is unfinished");

  a_counter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_EMIT |-> (i_r <= icnt_m1_r) && (j_r <= ocnt_m1_r))
    else $error("walk counter beyond its count");
`endif

endmodule

`default_nettype wire
